[rtl/bra_pkg.sv]
// shared types, codes and widths of the banker resource allocator
package bra_pkg;

    localparam int DEF_PROCESSES = 8;
    localparam int DEF_RESOURCES = 3;
    localparam int MAX_RESOURCES = 4;
    localparam int AMT_W         = 8;
    localparam int AVAIL_W       = 12;
    // available plus up to sixteen full allocations stays below 2**13
    localparam int WORK_W        = 13;

    typedef enum logic [2:0] {
        KIND_SET_AVAIL = 3'd0,
        KIND_SET_CLAIM = 3'd1,
        KIND_SET_ALLOC = 3'd2,
        KIND_REQUEST   = 3'd3,
        KIND_RELEASE   = 3'd4,
        KIND_CHECK     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_UNSAFE  = 2'd1,
        RES_ILLEGAL = 2'd2,
        RES_SHORT   = 2'd3
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_INIT,
        S_SCAN,
        S_ROLL_LOAD,
        S_ROLLBACK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_init;
        logic scan_step;
        logic load_pid_row;
        logic rollback;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  pid_ok;
        logic  over_need;
        logic  over_avail;
        logic  scan_end;
        logic  scan_safe;
    } stat_t;

endpackage

[rtl/bra_ctrl.sv]
// controller state machine and result register of the banker allocator
module bra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [1:0]        status,
    output bra_pkg::cmd_t     cmd,
    input  bra_pkg::stat_t    stat
);
    import bra_pkg::*;

    state_t  state_reg, state_next;
    result_t res_reg, res_next;
    result_t status_reg, status_next;
    logic    out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= RES_OK;
            status_reg    <= RES_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && result_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (stat.kind)
                    KIND_REQUEST:
                    begin
                        if (!stat.pid_ok || stat.over_need)
                        begin
                            res_next   = RES_ILLEGAL;
                            state_next = S_DONE;
                        end
                        else if (stat.over_avail)
                        begin
                            res_next   = RES_SHORT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_INIT;
                        end
                    end
                    KIND_CHECK:
                    begin
                        state_next = S_SCAN_INIT;
                    end
                    default:
                    begin
                        res_next   = RES_OK;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    if (stat.scan_safe)
                    begin
                        res_next   = RES_OK;
                        state_next = S_DONE;
                    end
                    else if (stat.kind == KIND_REQUEST)
                    begin
                        state_next = S_ROLL_LOAD;
                    end
                    else
                    begin
                        res_next   = RES_UNSAFE;
                        state_next = S_DONE;
                    end
                end
            end
            S_ROLL_LOAD:
            begin
                cmd.load_pid_row = 1'b1;
                state_next       = S_ROLLBACK;
            end
            S_ROLLBACK:
            begin
                cmd.rollback = 1'b1;
                res_next     = RES_UNSAFE;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign status       = status_reg;

endmodule

[rtl/bra_datapath.sv]
// state tables, request checks and the row-serial safety scan
module bra_datapath #(
    parameter int NUM_PROCESSES = bra_pkg::DEF_PROCESSES,
    parameter int NUM_RESOURCES = bra_pkg::DEF_RESOURCES
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic [2:0]                                        kind,
    input  logic [3:0]                                        pid,
    input  logic [bra_pkg::MAX_RESOURCES-1:0][bra_pkg::AMT_W-1:0] amount,
    input  bra_pkg::cmd_t                                     cmd,
    output bra_pkg::stat_t                                    stat
);
    import bra_pkg::*;

    localparam int ROW_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_PROCESSES - 1);

    // request latched at accept
    kind_t              kind_reg;
    logic               pid_ok_reg;
    logic [ROW_W-1:0]   pid_row_reg;
    logic [AMT_W-1:0]   amt_reg [NUM_RESOURCES];

    // allocator state
    logic [AVAIL_W-1:0] avail_reg [NUM_RESOURCES];
    logic [AMT_W-1:0]   claim_reg [NUM_PROCESSES][NUM_RESOURCES];
    logic [AMT_W-1:0]   alloc_reg [NUM_PROCESSES][NUM_RESOURCES];
    logic [AMT_W-1:0]   need_reg  [NUM_PROCESSES][NUM_RESOURCES];

    // scan state
    logic [ROW_W-1:0]         row_reg;
    logic [WORK_W-1:0]        work_reg [NUM_RESOURCES];
    logic [NUM_PROCESSES-1:0] done_reg;
    logic                     progress_reg;

    logic                     over_need;
    logic                     over_avail;
    logic                     fit;
    logic [NUM_PROCESSES-1:0] done_next;
    logic                     progress_next;
    logic                     all_done;
    logic                     scan_end;
    logic [AMT_W-1:0]         need_claim [NUM_RESOURCES];
    logic [AMT_W-1:0]         need_alloc [NUM_RESOURCES];
    logic [AVAIL_W-1:0]       avail_rel  [NUM_RESOURCES];
    logic [WORK_W-1:0]        rel_sum    [NUM_RESOURCES];

    always_comb
    begin
        over_need  = 1'b0;
        over_avail = 1'b0;
        fit        = !done_reg[row_reg];
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            if (amt_reg[r] > need_reg[row_reg][r])
                over_need = 1'b1;
            if ({{(AVAIL_W-AMT_W){1'b0}}, amt_reg[r]} > avail_reg[r])
                over_avail = 1'b1;
            if ({{(WORK_W-AMT_W){1'b0}}, need_reg[row_reg][r]} > work_reg[r])
                fit = 1'b0;
            // need after a claim write or an allocation write, floored at zero
            need_claim[r] = (amt_reg[r] > alloc_reg[row_reg][r]) ?
                            amt_reg[r] - alloc_reg[row_reg][r] : '0;
            need_alloc[r] = (claim_reg[row_reg][r] > amt_reg[r]) ?
                            claim_reg[row_reg][r] - amt_reg[r] : '0;
            rel_sum[r]    = {1'b0, avail_reg[r]} +
                            {{(WORK_W-AMT_W){1'b0}}, alloc_reg[row_reg][r]};
            avail_rel[r]  = rel_sum[r][WORK_W-1] ? '1 : rel_sum[r][AVAIL_W-1:0];
        end
        done_next = done_reg;
        if (fit)
            done_next[row_reg] = 1'b1;
        progress_next = progress_reg || fit;
        all_done      = &done_next;
        scan_end      = all_done || ((row_reg == LAST_ROW) && !progress_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_SET_AVAIL;
            pid_ok_reg   <= 1'b0;
            pid_row_reg  <= '0;
            row_reg      <= '0;
            done_reg     <= '0;
            progress_reg <= 1'b0;
            for (int r = 0; r < NUM_RESOURCES; r++)
            begin
                amt_reg[r]   <= '0;
                avail_reg[r] <= '0;
                work_reg[r]  <= '0;
            end
            for (int p = 0; p < NUM_PROCESSES; p++)
            begin
                for (int r = 0; r < NUM_RESOURCES; r++)
                begin
                    claim_reg[p][r] <= '0;
                    alloc_reg[p][r] <= '0;
                    need_reg[p][r]  <= '0;
                end
            end
        end
        else
        begin
            if (cmd.capture)
            begin
                kind_reg    <= kind_t'(kind);
                pid_ok_reg  <= (int'(pid) < NUM_PROCESSES);
                pid_row_reg <= pid[ROW_W-1:0];
                row_reg     <= pid[ROW_W-1:0];
                for (int r = 0; r < NUM_RESOURCES; r++)
                    amt_reg[r] <= amount[r];
            end

            if (cmd.exec)
            begin
                case (kind_reg)
                    KIND_SET_AVAIL:
                    begin
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            avail_reg[r] <= {{(AVAIL_W-AMT_W){1'b0}}, amt_reg[r]};
                    end
                    KIND_SET_CLAIM:
                    begin
                        if (pid_ok_reg)
                        begin
                            for (int r = 0; r < NUM_RESOURCES; r++)
                            begin
                                claim_reg[row_reg][r] <= amt_reg[r];
                                need_reg[row_reg][r]  <= need_claim[r];
                            end
                        end
                    end
                    KIND_SET_ALLOC:
                    begin
                        if (pid_ok_reg)
                        begin
                            for (int r = 0; r < NUM_RESOURCES; r++)
                            begin
                                alloc_reg[row_reg][r] <= amt_reg[r];
                                need_reg[row_reg][r]  <= need_alloc[r];
                            end
                        end
                    end
                    KIND_REQUEST:
                    begin
                        // tentative grant, undone after an unsafe scan
                        if (pid_ok_reg && !over_need && !over_avail)
                        begin
                            for (int r = 0; r < NUM_RESOURCES; r++)
                            begin
                                alloc_reg[row_reg][r] <= alloc_reg[row_reg][r] + amt_reg[r];
                                need_reg[row_reg][r]  <= need_reg[row_reg][r] - amt_reg[r];
                                avail_reg[r] <= avail_reg[r] -
                                                {{(AVAIL_W-AMT_W){1'b0}}, amt_reg[r]};
                            end
                        end
                    end
                    KIND_RELEASE:
                    begin
                        if (pid_ok_reg)
                        begin
                            for (int r = 0; r < NUM_RESOURCES; r++)
                            begin
                                avail_reg[r]          <= avail_rel[r];
                                alloc_reg[row_reg][r] <= '0;
                                need_reg[row_reg][r]  <= '0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.scan_init)
            begin
                row_reg      <= '0;
                done_reg     <= '0;
                progress_reg <= 1'b0;
                for (int r = 0; r < NUM_RESOURCES; r++)
                    work_reg[r] <= {1'b0, avail_reg[r]};
            end

            if (cmd.scan_step)
            begin
                done_reg <= done_next;
                if (fit)
                begin
                    for (int r = 0; r < NUM_RESOURCES; r++)
                        work_reg[r] <= work_reg[r] +
                                       {{(WORK_W-AMT_W){1'b0}}, alloc_reg[row_reg][r]};
                end
                if (row_reg == LAST_ROW)
                begin
                    row_reg      <= '0;
                    progress_reg <= 1'b0;
                end
                else
                begin
                    row_reg      <= row_reg + 1'b1;
                    progress_reg <= progress_next;
                end
            end

            if (cmd.load_pid_row)
                row_reg <= pid_row_reg;

            if (cmd.rollback)
            begin
                for (int r = 0; r < NUM_RESOURCES; r++)
                begin
                    alloc_reg[row_reg][r] <= alloc_reg[row_reg][r] - amt_reg[r];
                    need_reg[row_reg][r]  <= need_reg[row_reg][r] + amt_reg[r];
                    avail_reg[r] <= avail_reg[r] + {{(AVAIL_W-AMT_W){1'b0}}, amt_reg[r]};
                end
            end
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.pid_ok     = pid_ok_reg;
    assign stat.over_need  = over_need;
    assign stat.over_avail = over_avail;
    assign stat.scan_end   = scan_end;
    assign stat.scan_safe  = all_done;

endmodule

[rtl/banker_resource_allocator_core.sv]
// top level of the banker deadlock-avoidance resource allocator
// One request in, one status out. The block holds an available vector and, per
// process, a maximum claim, an allocation and a remaining need. Kinds: 0 sets
// available, 1 sets a claim, 2 sets an allocation (need = claim - allocation,
// floored at zero), 3 asks for units, 4 releases a process's units back to the
// pool (available saturates at 4095), 5 checks safety. A request that exceeds
// the need, or names no process, returns illegal (2); one that exceeds available
// returns insufficient (3); otherwise it is granted tentatively and the safety
// scan runs, and an unsafe outcome rolls the grant back and returns unsafe (1).
// Steps: loads, release and rejected requests pass from accept through the
// execute state to the done state. Check and surviving requests run the
// safety scan, which visits one process row per cycle with all resource
// compares in parallel and repeats the pass while some process finished in the
// previous one; an unsafe grant is then rolled back in the load and rollback
// states. All kinds end in the done state, which leaves for idle once the
// status is placed in the output register; the next request is taken in idle.
// One request is in work at a time; item_stall is high from accept until the
// status is placed in the output register, which holds it while result_stall
// is high.
module banker_resource_allocator_core #(
    parameter int NUM_PROCESSES = bra_pkg::DEF_PROCESSES,
    parameter int NUM_RESOURCES = bra_pkg::DEF_RESOURCES
) (
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [2:0] kind,
    input  logic [3:0] pid,
    input  logic [7:0] amount_0,
    input  logic [7:0] amount_1,
    input  logic [7:0] amount_2,
    input  logic [7:0] amount_3,
    // result channel
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] status
);
    import bra_pkg::*;

    // amounts of types at or beyond NUM_RESOURCES are not looked at
    logic [MAX_RESOURCES-1:0][AMT_W-1:0] amount;
    cmd_t  cmd;
    stat_t stat;

    assign amount[0] = amount_0;
    assign amount[1] = amount_1;
    assign amount[2] = amount_2;
    assign amount[3] = amount_3;

    // sequencing: accept, execute, scan, rollback, hand off the status
    bra_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd),
        .stat         (stat)
    );

    // state tables plus the row-serial safety scan
    bra_datapath #(
        .NUM_PROCESSES (NUM_PROCESSES),
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .kind   (kind),
        .pid    (pid),
        .amount (amount),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule
